>>> design/pscf_pkg.sv
// Shared types, register indexes and byte helpers for the PCM sample format converter.
package pscf_pkg;

	localparam int unsigned SAMPLE_W = 32;
	localparam int unsigned DEPTH_W  = 6;
	localparam int unsigned CFG_IDX_W = 4;

	localparam logic [SAMPLE_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [SAMPLE_W-1:0] SAT_MIN = 32'h8000_0000;

	// container width codes
	localparam logic [1:0] WCODE_8  = 2'd0;
	localparam logic [1:0] WCODE_16 = 2'd1;
	localparam logic [1:0] WCODE_24 = 2'd2;
	localparam logic [1:0] WCODE_32 = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_WIDTH_CODE  = 4'd0,
		REG_IN_DEPTH       = 4'd1,
		REG_IN_SIGNED      = 4'd2,
		REG_IN_BIG_ENDIAN  = 4'd3,
		REG_OUT_WIDTH_CODE = 4'd4,
		REG_OUT_DEPTH      = 4'd5,
		REG_OUT_SIGNED     = 4'd6,
		REG_OUT_BIG_ENDIAN = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         in_width_code;
		logic [DEPTH_W-1:0] in_depth;
		logic               in_signed;
		logic               in_big_endian;
		logic [1:0]         out_width_code;
		logic [DEPTH_W-1:0] out_depth;
		logic               out_signed;
		logic               out_big_endian;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		in_width_code:  WCODE_16,
		in_depth:       6'd16,
		in_signed:      1'b1,
		in_big_endian:  1'b0,
		out_width_code: WCODE_16,
		out_depth:      6'd16,
		out_signed:     1'b1,
		out_big_endian: 1'b0
	};

	// keep only the bytes of the container, zero above
	function automatic logic [SAMPLE_W-1:0] mask_bytes(input logic [SAMPLE_W-1:0] v,
		input logic [1:0] code);
		logic [SAMPLE_W-1:0] r;
		case (code)
			WCODE_8:  r = {24'd0, v[7:0]};
			WCODE_16: r = {16'd0, v[15:0]};
			WCODE_24: r = {8'd0, v[23:0]};
			default:  r = v;
		endcase
		return r;
	endfunction

	// reverse byte order within the container; input already masked
	function automatic logic [SAMPLE_W-1:0] swap_bytes(input logic [SAMPLE_W-1:0] v,
		input logic [1:0] code);
		logic [SAMPLE_W-1:0] r;
		case (code)
			WCODE_8:  r = {24'd0, v[7:0]};
			WCODE_16: r = {16'd0, v[7:0], v[15:8]};
			WCODE_24: r = {8'd0, v[7:0], v[15:8], v[23:16]};
			default:  r = {v[7:0], v[15:8], v[23:16], v[31:24]};
		endcase
		return r;
	endfunction

	// container width in bits: 8, 16, 24 or 32
	function automatic logic [DEPTH_W-1:0] width_bits(input logic [1:0] code);
		return ({4'd0, code} + 6'd1) << 3;
	endfunction

	// depth zero reads as one, depth above the container saturates to it
	function automatic logic [DEPTH_W-1:0] eff_depth(input logic [DEPTH_W-1:0] d,
		input logic [1:0] code);
		logic [DEPTH_W-1:0] w;
		w = width_bits(code);
		if (d == '0)
			return 6'd1;
		else if (d > w)
			return w;
		else
			return d;
	endfunction

endpackage

>>> design/pcm_sample_format_converter.sv
// PCM integer sample format converter: register file, input stage and result stage.
//
// Usage: one integer PCM sample per beat. The input channel (in_valid, in_stall,
// sample_bytes) carries the source container bytes, first stream byte in bits 7:0;
// bytes past the source container are ignored. The output channel (out_valid,
// out_stall, out_bytes) carries the converted container, unused upper bytes zero.
// The format comes from eight registers written over the cfg channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data); cfg_ready is always high and indexes past the
// register list are dropped. Write registers only while no sample is in flight.
// Path from input beat to output beat: the input register, then the result
// register fed by the unpack/scale/clamp/pack logic.
// Throughput: one sample per cycle; both registers advance every cycle while the
// receiver takes beats. Each stage advances whenever the stage after it is
// empty or moving, so a waiting result does not block a new input beat.
// Reset: registers return to signed 16-bit little endian in and out, both stages
// empty. When the receiver holds out_stall, the result holds, the input stage
// fills, and in_stall then rises until the result is taken.
module pcm_sample_format_converter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [pscf_pkg::SAMPLE_W-1:0]       sample_bytes,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [pscf_pkg::SAMPLE_W-1:0]       out_bytes,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pscf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pscf_pkg::DEPTH_W-1:0]        cfg_data
);

	pscf_pkg::cfg_t cfg_q;

	logic                              s1_valid;
	logic [pscf_pkg::SAMPLE_W-1:0]     s1_bytes;
	logic                              out_valid_q;
	logic [pscf_pkg::SAMPLE_W-1:0]     out_bytes_q;

	logic out_take;
	logic s1_move;

	// unpack side
	logic [pscf_pkg::DEPTH_W-1:0]  d_in;
	logic [pscf_pkg::DEPTH_W-1:0]  s_in;
	logic [pscf_pkg::SAMPLE_W-1:0] raw_le;
	logic [pscf_pkg::SAMPLE_W-1:0] raw;
	logic                          top_bit;
	logic [32:0]                   cur;
	logic [32:0]                   lo_mask;
	logic [63:0]                   wide;
	logic                          ovf;
	logic [pscf_pkg::SAMPLE_W-1:0] val;

	// pack side
	logic [pscf_pkg::DEPTH_W-1:0]  d_out;
	logic [pscf_pkg::DEPTH_W-1:0]  s_out;
	logic signed [31:0]            v_shift;
	logic [pscf_pkg::SAMPLE_W-1:0] v_off;
	logic [pscf_pkg::SAMPLE_W-1:0] v_mask;
	logic [pscf_pkg::SAMPLE_W-1:0] packed_bytes;

	// config writes; the channel never back-pressures
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= pscf_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pscf_pkg::REG_IN_WIDTH_CODE:  cfg_q.in_width_code  <= cfg_data[1:0];
				pscf_pkg::REG_IN_DEPTH:       cfg_q.in_depth       <= cfg_data;
				pscf_pkg::REG_IN_SIGNED:      cfg_q.in_signed      <= cfg_data[0];
				pscf_pkg::REG_IN_BIG_ENDIAN:  cfg_q.in_big_endian  <= cfg_data[0];
				pscf_pkg::REG_OUT_WIDTH_CODE: cfg_q.out_width_code <= cfg_data[1:0];
				pscf_pkg::REG_OUT_DEPTH:      cfg_q.out_depth      <= cfg_data;
				pscf_pkg::REG_OUT_SIGNED:     cfg_q.out_signed     <= cfg_data[0];
				pscf_pkg::REG_OUT_BIG_ENDIAN: cfg_q.out_big_endian <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// flow control: result register takes a beat when empty or being drained
	assign out_take = !out_valid_q || !out_stall;
	assign s1_move  = s1_valid && out_take;
	assign in_stall = s1_valid && !out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!in_stall) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			s1_bytes <= sample_bytes;
		end
	end

	// unpack: byte order, then make signed
	always_comb begin
		d_in    = pscf_pkg::eff_depth(cfg_q.in_depth, cfg_q.in_width_code);
		s_in    = 6'd32 - d_in;
		raw_le  = pscf_pkg::mask_bytes(s1_bytes, cfg_q.in_width_code);
		raw     = cfg_q.in_big_endian ? pscf_pkg::swap_bytes(raw_le, cfg_q.in_width_code)
		                              : raw_le;
		lo_mask = (33'd1 << d_in) - 33'd1;

		// offset binary flips the container's top bit, then both sign-extend from it (signed 24-bit from its depth bit)
		case (cfg_q.in_width_code)
			pscf_pkg::WCODE_8: begin
				top_bit = raw[7] ^ ~cfg_q.in_signed;
				cur     = {{26{top_bit}}, raw[6:0]};
			end
			pscf_pkg::WCODE_16: begin
				top_bit = raw[15] ^ ~cfg_q.in_signed;
				cur     = {{18{top_bit}}, raw[14:0]};
			end
			pscf_pkg::WCODE_24: begin
				top_bit = raw[23] ^ ~cfg_q.in_signed;
				if (!cfg_q.in_signed)
					cur = {{10{top_bit}}, raw[22:0]};
				else if (raw[5'(d_in - 6'd1)])
					// signed 24-bit extends from its depth bit
					cur = {1'b0, raw} | ~lo_mask;
				else
					cur = {1'b0, raw};
			end
			default: begin
				top_bit = raw[31] ^ ~cfg_q.in_signed;
				cur     = {{2{top_bit}}, raw[30:0]};
			end
		endcase

		// scale to 32-bit full scale and clamp
		wide = {{31{cur[32]}}, cur} << s_in;
		ovf  = !((&wide[63:31]) || !(|wide[63:31]));
		if (ovf)
			val = wide[63] ? pscf_pkg::SAT_MIN : pscf_pkg::SAT_MAX;
		else
			val = wide[31:0];
	end

	// pack: shift down to output depth, offset, byte order
	always_comb begin
		d_out   = pscf_pkg::eff_depth(cfg_q.out_depth, cfg_q.out_width_code);
		s_out   = 6'd32 - d_out;
		v_shift = $signed(val) >>> s_out;
		if (cfg_q.out_signed)
			v_off = v_shift;
		else
			v_off = v_shift + (32'd1 << (d_out - 6'd1));
		v_mask = pscf_pkg::mask_bytes(v_off, cfg_q.out_width_code);
		packed_bytes = cfg_q.out_big_endian
		             ? pscf_pkg::swap_bytes(v_mask, cfg_q.out_width_code)
		             : v_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_bytes_q <= packed_bytes;
		end
	end

	assign out_valid = out_valid_q;
	assign out_bytes = out_bytes_q;

	// an input beat always lands in the input stage
	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> s1_valid)
		else $error("accepted beat did not reach input stage");

	// back-pressure only with a full input stage
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid && out_valid_q && out_stall)
		else $error("input stalled without a full pipe");

	// a fresh result comes only from a held input beat
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(s1_valid))
		else $error("result appeared without an input beat");

	// byte-wide containers leave the upper bytes clear
	a_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cfg_q.out_width_code == pscf_pkg::WCODE_8 |-> out_bytes[31:8] == 24'd0)
		else $error("bytes beyond 8-bit container not zero");

endmodule

>>> tb/pscf_checker.sv
// Checker for the PCM sample format converter: predicts each converted sample and compares.
module pscf_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [pscf_pkg::SAMPLE_W-1:0]  sample_bytes,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [pscf_pkg::SAMPLE_W-1:0]  out_bytes,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [pscf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pscf_pkg::DEPTH_W-1:0]   cfg_data,
	output int                             pending,
	output int                             fail_count
);

	pscf_pkg::cfg_t                fmt;
	logic [pscf_pkg::SAMPLE_W-1:0] converted_q[$];
	logic [pscf_pkg::SAMPLE_W-1:0] want;
	int                            errors;

	function automatic logic [pscf_pkg::SAMPLE_W-1:0] container_mask(input int unsigned nbits);
		return (nbits == 32) ? '1 : ((32'd1 << nbits) - 32'd1);
	endfunction

	function automatic logic [pscf_pkg::SAMPLE_W-1:0] reverse_bytes(
		input logic [pscf_pkg::SAMPLE_W-1:0] v, input int unsigned nbytes);
		logic [pscf_pkg::SAMPLE_W-1:0] r;
		r = '0;
		for (int k = 0; k < nbytes; k++)
			r[8*(nbytes-1-k) +: 8] = v[8*k +: 8];
		return r;
	endfunction

	function automatic logic [pscf_pkg::SAMPLE_W-1:0] convert_sample(input pscf_pkg::cfg_t f,
		input logic [pscf_pkg::SAMPLE_W-1:0] bytes);
		int unsigned                   wi, wo, di, dout;
		logic [pscf_pkg::SAMPLE_W-1:0] raw;
		logic [pscf_pkg::SAMPLE_W-1:0] packed_bits;
		longint                        full;
		wi = 8 * (f.in_width_code + 1);
		wo = 8 * (f.out_width_code + 1);
		di = (f.in_depth == 0) ? 1 : ((f.in_depth > wi) ? wi : f.in_depth);
		dout = (f.out_depth == 0) ? 1 : ((f.out_depth > wo) ? wo : f.out_depth);

		// unpack: gather, make signed, scale to 32-bit full scale, clamp
		raw = bytes & container_mask(wi);
		if (f.in_big_endian)
			raw = reverse_bytes(raw, wi / 8);
		if (!f.in_signed) begin
			full = longint'({32'd0, raw}) - (longint'(1) << (wi - 1));
		end else if (wi == 24) begin
			// 24-bit signed extends from the depth bit, not from the container
			if (raw[di-1])
				full = longint'({32'd0, raw & container_mask(di)}) - (longint'(1) << di);
			else
				full = longint'({32'd0, raw});
		end else begin
			if (raw[wi-1])
				full = longint'({32'd0, raw}) - (longint'(1) << wi);
			else
				full = longint'({32'd0, raw});
		end
		full = full * (longint'(1) << (32 - di));
		if (full < -longint'({32'd0, pscf_pkg::SAT_MIN}))
			full = -longint'({32'd0, pscf_pkg::SAT_MIN});
		if (full > longint'({32'd0, pscf_pkg::SAT_MAX}))
			full = longint'({32'd0, pscf_pkg::SAT_MAX});

		// pack: shift down, offset unsigned, emit container
		full = full >>> (32 - dout);
		if (!f.out_signed)
			full = full + (longint'(1) << (dout - 1));
		packed_bits = full[31:0] & container_mask(wo);
		if (f.out_big_endian)
			packed_bits = reverse_bytes(packed_bits, wo / 8);
		return packed_bits;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt = pscf_pkg::CFG_RESET;
			converted_q.delete();
			errors = 0;
		end else begin
			// check the leaving beat first so a same-edge input is never matched to it
			if (out_valid && !out_stall) begin
				if (converted_q.size() == 0) begin
					$display("%0t: out_bytes expected none, actual %h", $time, out_bytes);
					errors++;
				end else begin
					want = converted_q.pop_front();
					if (out_bytes !== want) begin
						$display("%0t: out_bytes expected %h, actual %h", $time, want,
							out_bytes);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				converted_q.push_back(convert_sample(fmt, sample_bytes));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pscf_pkg::REG_IN_WIDTH_CODE:  fmt.in_width_code  = cfg_data[1:0];
					pscf_pkg::REG_IN_DEPTH:       fmt.in_depth       = cfg_data;
					pscf_pkg::REG_IN_SIGNED:      fmt.in_signed      = cfg_data[0];
					pscf_pkg::REG_IN_BIG_ENDIAN:  fmt.in_big_endian  = cfg_data[0];
					pscf_pkg::REG_OUT_WIDTH_CODE: fmt.out_width_code = cfg_data[1:0];
					pscf_pkg::REG_OUT_DEPTH:      fmt.out_depth      = cfg_data;
					pscf_pkg::REG_OUT_SIGNED:     fmt.out_signed     = cfg_data[0];
					pscf_pkg::REG_OUT_BIG_ENDIAN: fmt.out_big_endian = cfg_data[0];
					default: ;
				endcase
			end
		end
		pending <= converted_q.size();
		fail_count <= errors;
	end

endmodule

>>> tb/tb_top.sv
// Top of the PCM sample format converter testbench: clock, reset, stimulus and verdict.
module tb_top;

	localparam int ITEMS_PER_FORMAT = 84;
	localparam int FORMATS_PER_PHASE = 8;
	localparam int SETTLE_CYCLES = 4;     // two-stage pipe, plus margin
	localparam int STALL_LIMIT = 2000;    // cycles with no beat on any channel
	localparam logic [pscf_pkg::CFG_IDX_W-1:0] FIRST_UNUSED_IDX = 4'd8;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [pscf_pkg::SAMPLE_W-1:0]  sample_bytes = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [pscf_pkg::SAMPLE_W-1:0]  out_bytes;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [pscf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pscf_pkg::DEPTH_W-1:0]   cfg_data = '0;
	int                             pending;
	int                             fail_count;
	int                             send_idle = 0;   // percent of cycles the sender holds off
	int                             recv_idle = 0;   // percent of cycles the receiver stalls
	logic                           beat_seen;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	pcm_sample_format_converter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_bytes (sample_bytes),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_bytes    (out_bytes),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	pscf_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_bytes (sample_bytes),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_bytes    (out_bytes),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pending      (pending),
		.fail_count   (fail_count)
	);

	// Receiver: stall at random at the current rate; a rate of zero never stalls.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	// Any beat on any channel counts as progress.
	assign beat_seen = (in_valid && !in_stall) || (out_valid && !out_stall) ||
		(cfg_valid && cfg_ready);

	// Watchdog: end the run once the channels have been quiet for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (beat_seen)
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Offer one sample beat and hold it until taken. Valid stays high on exit so a
	// back-to-back beat follows without a gap; idle gaps come in front of a beat.
	task automatic send_sample(input logic [pscf_pkg::SAMPLE_W-1:0] bytes);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_bytes <= bytes;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drive one register write beat; the caller drops cfg_valid after the batch.
	task automatic write_reg(input logic [pscf_pkg::CFG_IDX_W-1:0] idx,
		input logic [pscf_pkg::DEPTH_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Write the whole format. Single-bit and width-code registers get random
	// upper data bits, which the block must drop; a write to an unused index
	// must leave every register alone.
	task automatic apply_format(input pscf_pkg::cfg_t f);
		write_reg(pscf_pkg::REG_IN_WIDTH_CODE, {4'($urandom), f.in_width_code});
		write_reg(pscf_pkg::REG_IN_DEPTH, f.in_depth);
		write_reg(pscf_pkg::REG_IN_SIGNED, {5'($urandom), f.in_signed});
		write_reg(pscf_pkg::REG_IN_BIG_ENDIAN, {5'($urandom), f.in_big_endian});
		write_reg(FIRST_UNUSED_IDX | 4'($urandom_range(7)), 6'($urandom));
		write_reg(pscf_pkg::REG_OUT_WIDTH_CODE, {4'($urandom), f.out_width_code});
		write_reg(pscf_pkg::REG_OUT_DEPTH, f.out_depth);
		write_reg(pscf_pkg::REG_OUT_SIGNED, {5'($urandom), f.out_signed});
		write_reg(pscf_pkg::REG_OUT_BIG_ENDIAN, {5'($urandom), f.out_big_endian});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid and wait until every predicted sample has come out. Wait on the
	// clock first so a beat taken at the last edge is already counted.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Mostly legal depths, with depth zero and depths above the container mixed in.
	function automatic logic [pscf_pkg::DEPTH_W-1:0] random_depth(input logic [1:0] code);
		int unsigned w;
		w = 8 * (code + 1);
		case ($urandom_range(9))
			0: return '0;
			1: return 6'($urandom);
			2: return 6'(w);
			3: return 6'd1;
			default: return 6'($urandom_range(w, 1));
		endcase
	endfunction

	function automatic pscf_pkg::cfg_t random_format();
		pscf_pkg::cfg_t f;
		f.in_width_code = 2'($urandom);
		f.in_depth = random_depth(f.in_width_code);
		f.in_signed = 1'($urandom);
		f.in_big_endian = 1'($urandom);
		f.out_width_code = 2'($urandom);
		f.out_depth = random_depth(f.out_width_code);
		f.out_signed = 1'($urandom);
		f.out_big_endian = 1'($urandom);
		return f;
	endfunction

	// Bias toward full-scale and sign-boundary bytes; the rest is uniform.
	function automatic logic [pscf_pkg::SAMPLE_W-1:0] random_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return 32'h8080_8080;
			3: return 32'h7F7F_7F7F;
			4: return 32'h0000_0080 << (8 * $urandom_range(3));
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [pscf_pkg::SAMPLE_W-1:0] at_reset[5];
		logic [pscf_pkg::SAMPLE_W-1:0] depth_edges[4];
		logic [pscf_pkg::SAMPLE_W-1:0] deep24[5];
		logic [pscf_pkg::SAMPLE_W-1:0] wide32[4];
		logic [pscf_pkg::SAMPLE_W-1:0] narrow8[4];
		int sender_rate[3];
		int receiver_rate[3];

		// signed 16-bit little endian after reset: zero, full scale, sign edges,
		// upper bytes that must be ignored
		at_reset = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_7FFF, 32'hABCD_8000,
			32'h0000_0001};
		// depth zero reads as one; depth 63 saturates to the 32-bit container
		depth_edges = '{32'h0000_0000, 32'h0000_0080, 32'hFFFF_FFFF, 32'h00FF_FF7F};
		// 24-bit signed at depth 20: depth bit set, clear, and stray upper bits
		deep24 = '{32'h0007_FFFF, 32'h0008_0000, 32'h00F0_0000, 32'h00FF_FFFF,
			32'h0000_0000};
		wide32 = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
		narrow8 = '{32'h0000_0000, 32'h0000_00FF, 32'h0000_0080, 32'h0000_007F};
		sender_rate = '{25, 77, 0};
		receiver_rate = '{77, 25, 0};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling.
		foreach (at_reset[i])
			send_sample(at_reset[i]);
		wait_drained();

		apply_format('{in_width_code: pscf_pkg::WCODE_24, in_depth: 6'd0, in_signed: 1'b1,
			in_big_endian: 1'b1, out_width_code: pscf_pkg::WCODE_32, out_depth: 6'd63,
			out_signed: 1'b0, out_big_endian: 1'b1});
		foreach (depth_edges[i])
			send_sample(depth_edges[i]);
		wait_drained();

		apply_format('{in_width_code: pscf_pkg::WCODE_24, in_depth: 6'd20, in_signed: 1'b1,
			in_big_endian: 1'b0, out_width_code: pscf_pkg::WCODE_8, out_depth: 6'd8,
			out_signed: 1'b0, out_big_endian: 1'b0});
		foreach (deep24[i])
			send_sample(deep24[i]);
		wait_drained();

		apply_format('{in_width_code: pscf_pkg::WCODE_32, in_depth: 6'd32, in_signed: 1'b0,
			in_big_endian: 1'b0, out_width_code: pscf_pkg::WCODE_24, out_depth: 6'd24,
			out_signed: 1'b1, out_big_endian: 1'b1});
		foreach (wide32[i])
			send_sample(wide32[i]);
		wait_drained();

		apply_format('{in_width_code: pscf_pkg::WCODE_8, in_depth: 6'd8, in_signed: 1'b0,
			in_big_endian: 1'b1, out_width_code: pscf_pkg::WCODE_16, out_depth: 6'd1,
			out_signed: 1'b0, out_big_endian: 1'b1});
		foreach (narrow8[i])
			send_sample(narrow8[i]);
		wait_drained();

		// Random part: three idling phases, several formats each. Formats only
		// change once the pipe has drained.
		foreach (sender_rate[p]) begin
			send_idle = sender_rate[p];
			recv_idle = receiver_rate[p];
			repeat (FORMATS_PER_PHASE) begin
				apply_format(random_format());
				repeat (ITEMS_PER_FORMAT)
					send_sample(random_sample());
				wait_drained();
			end
		end

		// Let any stray beat surface before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> pcm_sample_format_converter.f
design/pscf_pkg.sv
design/pcm_sample_format_converter.sv
tb/pscf_checker.sv
tb/tb_top.sv
